// ===== sv/mops_pkg.sv =====
package mops_pkg;

    // Design constants.
    localparam int COORD_BITS = 4;
    localparam int PORT_BITS  = 4;

    localparam int ID_W       = 12;
    localparam int SIZE_W     = 5;
    localparam int HERE_W     = (COORD_BITS < 4) ? COORD_BITS : 4;
    localparam int NUM_DIRS   = 7;
    localparam int MAP_W      = NUM_DIRS * PORT_BITS;
    localparam int CFG_DATA_W = (MAP_W > SIZE_W) ? MAP_W : SIZE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_PORT_W = 4;

    // Each division stage retires this many quotient bits.
    localparam int DIV_STEPS      = 4;
    localparam int STAGES_PER_DIV = ID_W / DIV_STEPS;
    localparam int NUM_DIV_ST     = 2 * STAGES_PER_DIV;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 3'd0,
        CFG_ROWS      = 3'd1,
        CFG_HERE_X    = 3'd2,
        CFG_HERE_Y    = 3'd3,
        CFG_HERE_LAYER = 3'd4,
        CFG_PORT_MAP  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_N    = 3'd0,
        DIR_W    = 3'd1,
        DIR_S    = 3'd2,
        DIR_E    = 3'd3,
        DIR_CORE = 3'd4,
        DIR_UP   = 3'd5,
        DIR_LOW  = 3'd6
    } t_dir;

    // Payload of one division stage.
    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [ID_W-1:0]   quo;
        logic [ID_W-1:0]   num;
        logic [SIZE_W-1:0] dx;
    } t_pipe;

    // Restoring division, DIV_STEPS bits taken from the top of num.
    function automatic t_pipe div_steps(t_pipe p, logic [SIZE_W-1:0] dvs);
        t_pipe           r;
        logic [SIZE_W:0] sh;
        r = p;
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh    = {r.rem, r.num[ID_W-1]};
            r.num = {r.num[ID_W-2:0], 1'b0};
            if (sh >= {1'b0, dvs}) begin
                r.rem = SIZE_W'(sh - {1'b0, dvs});
                r.quo = {r.quo[ID_W-2:0], 1'b1};
            end else begin
                r.rem = sh[SIZE_W-1:0];
                r.quo = {r.quo[ID_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/mesh3d_output_port_select.sv =====
// Throughput: one request per cycle while the receiver does not hold a finished
// result; the six stages of the two pipelined id divisions (four quotient bits
// each), the direction stage and the port lookup stage all advance together.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers to a 1x1 mesh at the origin with no ports present.
module mesh3d_output_port_select
    import mops_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ID_W-1:0]       i_dest_id,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_PORT_W-1:0] o_out_port,
    output logic                  o_dead_end
);

    // Configuration registers.
    logic [SIZE_W-1:0] r_cols;
    logic [SIZE_W-1:0] r_rows;
    logic [HERE_W-1:0] r_here_x;
    logic [HERE_W-1:0] r_here_y;
    logic [HERE_W-1:0] r_here_layer;
    logic [MAP_W-1:0]  r_port_map;

    logic [SIZE_W-1:0] w_cols_eff;
    logic [SIZE_W-1:0] w_rows_eff;

    // Pipeline.
    t_pipe                 r_pipe [NUM_DIV_ST];
    t_pipe                 n_pipe [NUM_DIV_ST];
    logic [NUM_DIV_ST-1:0] r_pipe_vld;
    t_dir                  r_dir;
    t_dir                  n_dir;
    logic                  r_dir_vld;
    logic                  r_out_vld;
    logic [OUT_PORT_W-1:0] r_out_port;
    logic                  r_dead_end;
    logic [PORT_BITS-1:0]  w_port;
    logic                  w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols       <= SIZE_W'(1);
            r_rows       <= SIZE_W'(1);
            r_here_x     <= '0;
            r_here_y     <= '0;
            r_here_layer <= '0;
            r_port_map   <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMNS:    r_cols       <= i_cfg_data[SIZE_W-1:0];
                CFG_ROWS:       r_rows       <= i_cfg_data[SIZE_W-1:0];
                CFG_HERE_X:     r_here_x     <= i_cfg_data[HERE_W-1:0];
                CFG_HERE_Y:     r_here_y     <= i_cfg_data[HERE_W-1:0];
                CFG_HERE_LAYER: r_here_layer <= i_cfg_data[HERE_W-1:0];
                CFG_PORT_MAP:   r_port_map   <= i_cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero size is treated as one so that the decode never divides by zero.
    assign w_cols_eff = (r_cols == '0) ? SIZE_W'(1) : r_cols;
    assign w_rows_eff = (r_rows == '0) ? SIZE_W'(1) : r_rows;

    // The whole pipeline moves unless a finished result is held by the receiver.
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    // Division stages: the first half computes id / columns, the second half
    // divides that quotient by rows, giving the layer and the row.
    always_comb begin
        t_pipe src;
        src       = '0;
        src.num   = i_dest_id;
        n_pipe[0] = div_steps(src, w_cols_eff);
        for (int s = 1; s < NUM_DIV_ST; s++) begin
            src = r_pipe[s-1];
            if (s == STAGES_PER_DIV) begin
                src.dx  = r_pipe[s-1].rem;
                src.num = r_pipe[s-1].quo;
                src.rem = '0;
                src.quo = '0;
            end
            n_pipe[s] = div_steps(src, (s < STAGES_PER_DIV) ? w_cols_eff : w_rows_eff);
        end
    end

    // Direction choice from the decoded coordinates, compared at full width.
    always_comb begin
        logic [ID_W-1:0] dx;
        logic [ID_W-1:0] dy;
        logic [ID_W-1:0] dz;
        logic [ID_W-1:0] hx;
        logic [ID_W-1:0] hy;
        logic [ID_W-1:0] hz;
        t_dir            planar;
        dx = ID_W'(r_pipe[NUM_DIV_ST-1].dx);
        dy = ID_W'(r_pipe[NUM_DIV_ST-1].rem);
        dz = r_pipe[NUM_DIV_ST-1].quo;
        hx = ID_W'(r_here_x);
        hy = ID_W'(r_here_y);
        hz = ID_W'(r_here_layer);
        if (dx > hx) begin
            planar = DIR_E;
        end else if (dx < hx) begin
            planar = DIR_W;
        end else if (dy > hy) begin
            planar = DIR_N;
        end else if (dy < hy) begin
            planar = DIR_S;
        end else begin
            planar = DIR_CORE;
        end
        if (!r_here_layer[0]) begin
            // Even layer: planar first, then the layer move.
            n_dir = planar;
            if (planar == DIR_CORE && dz > hz) begin
                n_dir = DIR_LOW;
            end else if (planar == DIR_CORE && dz < hz) begin
                n_dir = DIR_UP;
            end
        end else begin
            if (dz > hz) begin
                n_dir = DIR_UP;
            end else if (dz < hz) begin
                n_dir = DIR_LOW;
            end else begin
                n_dir = planar;
            end
        end
    end

    always_comb begin
        case (r_dir)
            DIR_N:    w_port = r_port_map[0*PORT_BITS +: PORT_BITS];
            DIR_W:    w_port = r_port_map[1*PORT_BITS +: PORT_BITS];
            DIR_S:    w_port = r_port_map[2*PORT_BITS +: PORT_BITS];
            DIR_E:    w_port = r_port_map[3*PORT_BITS +: PORT_BITS];
            DIR_CORE: w_port = r_port_map[4*PORT_BITS +: PORT_BITS];
            DIR_UP:   w_port = r_port_map[5*PORT_BITS +: PORT_BITS];
            DIR_LOW:  w_port = r_port_map[6*PORT_BITS +: PORT_BITS];
            default:  w_port = '1;
        endcase
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_vld <= '0;
            r_dir_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (w_adv) begin
            r_pipe_vld <= {r_pipe_vld[NUM_DIV_ST-2:0], i_valid};
            r_dir_vld  <= r_pipe_vld[NUM_DIV_ST-1];
            r_out_vld  <= r_dir_vld;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NUM_DIV_ST; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
            r_dir      <= n_dir;
            r_out_port <= OUT_PORT_W'(w_port);
            r_dead_end <= (w_port == '1);
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_port = r_out_port;
    assign o_dead_end = r_dead_end;

    // An accepted request always enters the first division stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_pipe_vld[0])
        else $error("accepted request did not enter the pipeline");

    // The column remainder is below the column count when the first division ends.
    a_col_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_vld[STAGES_PER_DIV-1] |-> (r_pipe[STAGES_PER_DIV-1].rem < w_cols_eff))
        else $error("column remainder out of range");

    // The row remainder is below the row count when the second division ends.
    a_row_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_vld[NUM_DIV_ST-1] |-> (r_pipe[NUM_DIV_ST-1].rem < w_rows_eff))
        else $error("row remainder out of range");

    // A held result keeps the pipeline frozen.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_dir_vld == $past(r_dir_vld)))
        else $error("pipeline moved while the result was held");

endmodule
